FILE: rtl/bchc_pkg.sv
// Shared types and constants for the button click/hold classifier.
// Used by bchc_cfg_regs, bchc_core and button_click_hold_classifier_unit; no dependencies.
package bchc_pkg;

	localparam int unsigned TimeWidth = 32;
	localparam int unsigned CfgWidth  = 16;
	localparam int unsigned IdxWidth  = 3;

	typedef logic [TimeWidth-1:0] ms_t;
	typedef logic [CfgWidth-1:0]  cfg_word_t;

	// Event and shown-state encoding.
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_CLICK  = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_HOLD   = 3'd3,
		EV_LONG   = 3'd4
	} event_t;

	// Register indexes on the configuration port.
	typedef enum logic [IdxWidth-1:0] {
		CFG_DEBOUNCE = 3'd0,
		CFG_DC_GAP   = 3'd1,
		CFG_HOLD     = 3'd2,
		CFG_LONG     = 3'd3,
		CFG_MEM_DLY  = 3'd4
	} cfg_idx_t;

	localparam cfg_word_t DebounceRst = 16'd50;
	localparam cfg_word_t DcGapRst    = 16'd250;
	localparam cfg_word_t HoldRst     = 16'd300;
	localparam cfg_word_t LongRst     = 16'd1000;
	localparam cfg_word_t MemDlyRst   = 16'd200;

	typedef struct packed {
		cfg_word_t debounce_ms;
		cfg_word_t double_click_gap_ms;
		cfg_word_t hold_ms;
		cfg_word_t long_hold_ms;
		cfg_word_t memory_delay_ms;
	} cfg_t;

	// Classifier state carried from one poll to the next.
	typedef struct packed {
		logic   prev_level;
		ms_t    press_time;
		ms_t    release_time;
		logic   awaiting_second;
		logic   double_on_release;
		logic   single_allowed;
		logic   skip_release;
		logic   hold_done;
		logic   long_hold_done;
		ms_t    refresh_time;
		event_t latched_state;
	} cls_state_t;

endpackage

FILE: rtl/bchc_cfg_regs.sv
// Configuration register file for the button click/hold classifier.
// Depends on bchc_pkg for the register indexes, reset values and cfg_t.
module bchc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bchc_pkg::IdxWidth-1:0] cfg_index,
	input  bchc_pkg::cfg_word_t         cfg_data,
	output bchc_pkg::cfg_t              cfg
);

	bchc_pkg::cfg_t cfg_q;

	// Indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= bchc_pkg::DebounceRst;
			cfg_q.double_click_gap_ms <= bchc_pkg::DcGapRst;
			cfg_q.hold_ms             <= bchc_pkg::HoldRst;
			cfg_q.long_hold_ms        <= bchc_pkg::LongRst;
			cfg_q.memory_delay_ms     <= bchc_pkg::MemDlyRst;
		end else if (cfg_we) begin
			case (cfg_index)
				bchc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms         <= cfg_data;
				bchc_pkg::CFG_DC_GAP:   cfg_q.double_click_gap_ms <= cfg_data;
				bchc_pkg::CFG_HOLD:     cfg_q.hold_ms             <= cfg_data;
				bchc_pkg::CFG_LONG:     cfg_q.long_hold_ms        <= cfg_data;
				bchc_pkg::CFG_MEM_DLY:  cfg_q.memory_delay_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/bchc_core.sv
// Classifier state registers and the per-poll update logic.
// Depends on bchc_pkg for cfg_t, cls_state_t and the event encoding.
module bchc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               level,
	input  bchc_pkg::ms_t      now,
	input  bchc_pkg::cfg_t     cfg,
	output bchc_pkg::event_t   ev,
	output bchc_pkg::event_t   shown
);

	bchc_pkg::cls_state_t st_q;
	bchc_pkg::cls_state_t st_d;
	bchc_pkg::event_t     ev_d;

	always_comb begin
		bchc_pkg::ms_t since_up;
		bchc_pkg::ms_t since_rel;
		bchc_pkg::ms_t down_for;
		bchc_pkg::ms_t since_refresh;
		logic          press_edge;
		logic          rel_edge;

		st_d = st_q;
		ev_d = bchc_pkg::EV_NONE;

		since_up   = now - st_q.release_time;
		down_for   = now - st_q.press_time;
		press_edge = !level && st_q.prev_level &&
			(since_up > {16'd0, cfg.debounce_ms});
		rel_edge   = !press_edge && level && !st_q.prev_level &&
			(down_for > {16'd0, cfg.debounce_ms});

		if (press_edge) begin
			st_d.press_time        = now;
			st_d.skip_release      = 1'b0;
			st_d.single_allowed    = 1'b1;
			st_d.hold_done         = 1'b0;
			st_d.long_hold_done    = 1'b0;
			st_d.double_on_release = (since_up < {16'd0, cfg.double_click_gap_ms}) &&
				!st_q.double_on_release && st_q.awaiting_second;
			st_d.awaiting_second   = 1'b0;
		end else if (rel_edge && !st_q.skip_release) begin
			st_d.release_time = now;
			if (!st_q.double_on_release) begin
				st_d.awaiting_second = 1'b1;
			end else begin
				ev_d                   = bchc_pkg::EV_DOUBLE;
				st_d.double_on_release = 1'b0;
				st_d.awaiting_second   = 1'b0;
				st_d.single_allowed    = 1'b0;
			end
		end

		// The release stamp may have just moved to now.
		since_rel = now - st_d.release_time;
		if (level && (since_rel >= {16'd0, cfg.double_click_gap_ms}) &&
				st_d.awaiting_second && !st_d.double_on_release &&
				st_d.single_allowed && (ev_d != bchc_pkg::EV_DOUBLE)) begin
			ev_d                 = bchc_pkg::EV_CLICK;
			st_d.awaiting_second = 1'b0;
		end

		// Hold timing uses the press stamp as it stands after this poll.
		down_for = now - st_d.press_time;
		if (!level && (down_for >= {16'd0, cfg.hold_ms})) begin
			if (!st_d.hold_done) begin
				ev_d                   = bchc_pkg::EV_HOLD;
				st_d.skip_release      = 1'b1;
				st_d.double_on_release = 1'b0;
				st_d.awaiting_second   = 1'b0;
				st_d.hold_done         = 1'b1;
			end
			if ((down_for >= {16'd0, cfg.long_hold_ms}) && !st_d.long_hold_done) begin
				ev_d                = bchc_pkg::EV_LONG;
				st_d.long_hold_done = 1'b1;
			end
		end

		st_d.prev_level = level;

		since_refresh = now - st_q.refresh_time;
		if (ev_d == bchc_pkg::EV_NONE) begin
			if (since_refresh > {16'd0, cfg.memory_delay_ms}) begin
				st_d.latched_state = bchc_pkg::EV_NONE;
				st_d.refresh_time  = now;
			end
		end else begin
			st_d.latched_state = ev_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prev_level        <= 1'b1;
			st_q.press_time        <= '1;
			st_q.release_time      <= '1;
			st_q.awaiting_second   <= 1'b0;
			st_q.double_on_release <= 1'b0;
			st_q.single_allowed    <= 1'b1;
			st_q.skip_release      <= 1'b0;
			st_q.hold_done         <= 1'b0;
			st_q.long_hold_done    <= 1'b0;
			st_q.refresh_time      <= '0;
			st_q.latched_state     <= bchc_pkg::EV_NONE;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	assign ev    = ev_d;
	assign shown = st_d.latched_state;

endmodule

FILE: rtl/button_click_hold_classifier_unit.sv
// Top level of the button click/hold classifier: poll register, classifier core,
// result register. Depends on bchc_pkg, bchc_cfg_regs and bchc_core.

// Each beat on the poll channel is one sample of an active-low button (pin level
// and a free-running millisecond time). The block answers every poll with exactly
// one result beat: the event of that poll (none, click, double click, hold, long
// hold) and the latched shown state. It sustains one poll per clock cycle
// while the result side is not stalled. A poll is first taken into the poll
// register, which feeds the classifier, and its update lands in the result
// register when the result side can accept. Stalls on the result side hold the
// pipeline without losing beats. The configuration registers are written
// through cfg_we/cfg_index/cfg_data and must only be changed while no poll is
// in flight. All elapsed times are computed modulo 2^32.
module button_click_hold_classifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Poll channel.
	input  logic                          poll_valid,
	output logic                          poll_ready,
	input  logic                          button_level,
	input  logic [31:0]                   now_ms,
	// Result channel.
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [2:0]                    event_code,
	output logic [2:0]                    shown_state,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [bchc_pkg::IdxWidth-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	bchc_pkg::cfg_t   cfg;
	logic             valid_s1;
	logic             level_s1;
	bchc_pkg::ms_t    now_s1;
	logic             valid_s2;
	bchc_pkg::event_t ev_s2;
	bchc_pkg::event_t shown_s2;
	bchc_pkg::event_t core_ev;
	bchc_pkg::event_t core_shown;
	logic             advance;
	logic             step;

	bchc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register can take a new beat when it is empty or being drained.
	assign advance    = !valid_s2 || result_ready;
	// The poll register moves into the core whenever the result side can accept.
	assign step       = valid_s1 && advance;
	assign poll_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			level_s1 <= button_level;
			now_s1   <= now_ms;
		end
	end

	// The core updates its state only on the cycle a poll is classified, so the
	// next poll always sees the state left by the previous one.
	bchc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (level_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.ev     (core_ev),
		.shown  (core_shown)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_s2    <= core_ev;
			shown_s2 <= core_shown;
		end
	end

	assign result_valid = valid_s2;
	assign event_code   = ev_s2;
	assign shown_state  = shown_s2;

	// Any reported event is also the shown state of the same result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (event_code != bchc_pkg::EV_NONE)) |-> (shown_state == event_code))
		else $error("shown state does not follow a reported event");

	// A poll is never taken while both stages are full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(poll_valid && poll_ready) |-> !(valid_s1 && valid_s2 && !result_ready))
		else $error("poll accepted into a full pipeline");

	// A classified poll always lands in the result register on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> result_valid)
		else $error("classified poll did not produce a result");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the button click/hold classifier top level.
// Depends on bchc_pkg and button_click_hold_classifier_unit with its submodules.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no beat on either channel before the run is declared hung. The
	// slowest correct run stalls far less than this, even with a 49 percent stall.
	localparam int WatchdogLimit = 2000;
	// Extra cycles after the last awaited result. A result passes the poll register
	// and then the result register, so this covers the pipeline with margin.
	localparam int DrainCycles   = 4;

	// One awaited result beat: the event of a poll and the shown state after it.
	typedef struct {
		bchc_pkg::event_t ev;
		bchc_pkg::event_t shown;
	} poll_outcome_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          poll_valid   = 1'b0;
	logic                          poll_ready;
	logic                          button_level = 1'b1;
	logic [31:0]                   now_ms       = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [2:0]                    event_code;
	logic [2:0]                    shown_state;
	logic                          cfg_we       = 1'b0;
	logic [bchc_pkg::IdxWidth-1:0] cfg_index    = '0;
	logic [15:0]                   cfg_data     = '0;

	// Outcomes of accepted polls whose result beats have not arrived yet.
	poll_outcome_t awaited_outcomes[$];
	poll_outcome_t head_outcome;
	int            mismatch_count = 0;
	int            polls_sent     = 0;
	int            quiet_cycles   = 0;
	// Percent of cycles in which each side holds back.
	int            send_idle_pct  = 23;
	int            recv_idle_pct  = 49;
	// Free-running millisecond clock that the stimulus advances poll by poll.
	bchc_pkg::ms_t clock_ms       = '0;

	// Classifier state as this testbench tracks it, plus its view of the registers.
	logic                little_unused_guard;
	logic                was_up;
	bchc_pkg::ms_t       pressed_at;
	bchc_pkg::ms_t       released_at;
	logic                click_pending;
	logic                double_armed;
	logic                click_allowed;
	logic                ignore_release;
	logic                hold_seen;
	logic                long_seen;
	bchc_pkg::ms_t       refreshed_at;
	bchc_pkg::event_t    shown_now;
	bchc_pkg::cfg_word_t debounce_cfg;
	bchc_pkg::cfg_word_t gap_cfg;
	bchc_pkg::cfg_word_t hold_cfg;
	bchc_pkg::cfg_word_t long_cfg;
	bchc_pkg::cfg_word_t mem_delay_cfg;

	button_click_hold_classifier_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_ready   (poll_ready),
		.button_level (button_level),
		.now_ms       (now_ms),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.event_code   (event_code),
		.shown_state  (shown_state),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Put the tracked state and registers at their values after reset.
	function automatic void clear_classifier();
		was_up         = 1'b1;
		pressed_at     = '1;
		released_at    = '1;
		click_pending  = 1'b0;
		double_armed   = 1'b0;
		click_allowed  = 1'b1;
		ignore_release = 1'b0;
		hold_seen      = 1'b0;
		long_seen      = 1'b0;
		refreshed_at   = '0;
		shown_now      = bchc_pkg::EV_NONE;
		debounce_cfg   = bchc_pkg::DebounceRst;
		gap_cfg        = bchc_pkg::DcGapRst;
		hold_cfg       = bchc_pkg::HoldRst;
		long_cfg       = bchc_pkg::LongRst;
		mem_delay_cfg  = bchc_pkg::MemDlyRst;
	endfunction

	// Advance the tracked state by one poll and return the result beat it causes.
	// Every elapsed time is a 32-bit difference, so it wraps like the block's timer.
	function automatic poll_outcome_t classify_poll(input logic level,
			input bchc_pkg::ms_t t);
		poll_outcome_t res;
		bchc_pkg::ms_t since_up;
		bchc_pkg::ms_t down_for;
		res.ev   = bchc_pkg::EV_NONE;
		since_up = t - released_at;
		if (!level && was_up && since_up > bchc_pkg::ms_t'(debounce_cfg)) begin
			// A press edge that clears the debounce window starts a new press.
			pressed_at     = t;
			ignore_release = 1'b0;
			click_allowed  = 1'b1;
			hold_seen      = 1'b0;
			long_seen      = 1'b0;
			double_armed   = since_up < bchc_pkg::ms_t'(gap_cfg) && !double_armed &&
				click_pending;
			click_pending  = 1'b0;
		end else if (level && !was_up &&
				bchc_pkg::ms_t'(t - pressed_at) > bchc_pkg::ms_t'(debounce_cfg)) begin
			// A counted release is dropped entirely once a hold has fired on this press.
			if (!ignore_release) begin
				released_at = t;
				if (!double_armed) begin
					click_pending = 1'b1;
				end else begin
					res.ev        = bchc_pkg::EV_DOUBLE;
					double_armed  = 1'b0;
					click_pending = 1'b0;
					click_allowed = 1'b0;
				end
			end
		end
		// A single click is only known once the second press failed to come in time.
		if (level && bchc_pkg::ms_t'(t - released_at) >= bchc_pkg::ms_t'(gap_cfg) &&
				click_pending && !double_armed && click_allowed &&
				res.ev != bchc_pkg::EV_DOUBLE) begin
			res.ev        = bchc_pkg::EV_CLICK;
			click_pending = 1'b0;
		end
		// Hold tests run off the last counted press stamp, whatever edges came since.
		if (!level) begin
			down_for = t - pressed_at;
			if (down_for >= bchc_pkg::ms_t'(hold_cfg)) begin
				if (!hold_seen) begin
					res.ev         = bchc_pkg::EV_HOLD;
					ignore_release = 1'b1;
					double_armed   = 1'b0;
					click_pending  = 1'b0;
					hold_seen      = 1'b1;
				end
				if (down_for >= bchc_pkg::ms_t'(long_cfg) && !long_seen) begin
					res.ev    = bchc_pkg::EV_LONG;
					long_seen = 1'b1;
				end
			end
		end
		was_up = level;
		// The shown state only falls back to released on a quiet poll after its delay.
		if (res.ev == bchc_pkg::EV_NONE) begin
			if (bchc_pkg::ms_t'(t - refreshed_at) > bchc_pkg::ms_t'(mem_delay_cfg)) begin
				shown_now    = bchc_pkg::EV_NONE;
				refreshed_at = t;
			end
		end else begin
			shown_now = res.ev;
		end
		res.shown = shown_now;
		return res;
	endfunction

	// Offer one poll beat, possibly after a random gap, and record its outcome once
	// the block takes it. Returns in the time step of the accepting edge, so the
	// caller either offers the next beat or drops valid in that same step.
	task automatic send_poll(input logic level, input bchc_pkg::ms_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			poll_valid <= 1'b0;
			@(posedge clk);
		end
		poll_valid   <= 1'b1;
		button_level <= level;
		now_ms       <= t;
		do @(posedge clk); while (!poll_ready);
		awaited_outcomes.push_back(classify_poll(level, t));
		polls_sent++;
	endtask

	// Stop offering polls and wait until every awaited result beat has arrived.
	task automatic wait_drain();
		poll_valid <= 1'b0;
		@(posedge clk);
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write one register; indexes past the last register are ignored by the block.
	task automatic write_reg(input logic [bchc_pkg::IdxWidth-1:0] idx,
			input bchc_pkg::cfg_word_t value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			bchc_pkg::CFG_DEBOUNCE: debounce_cfg  = value;
			bchc_pkg::CFG_DC_GAP:   gap_cfg       = value;
			bchc_pkg::CFG_HOLD:     hold_cfg      = value;
			bchc_pkg::CFG_LONG:     long_cfg      = value;
			bchc_pkg::CFG_MEM_DLY:  mem_delay_cfg = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(input bchc_pkg::cfg_word_t deb,
			input bchc_pkg::cfg_word_t gap, input bchc_pkg::cfg_word_t hld,
			input bchc_pkg::cfg_word_t lng, input bchc_pkg::cfg_word_t mem);
		wait_drain();
		write_reg(bchc_pkg::CFG_DEBOUNCE, deb);
		write_reg(bchc_pkg::CFG_DC_GAP, gap);
		write_reg(bchc_pkg::CFG_HOLD, hld);
		write_reg(bchc_pkg::CFG_LONG, lng);
		write_reg(bchc_pkg::CFG_MEM_DLY, mem);
	endtask

	function automatic bchc_pkg::cfg_word_t any_threshold();
		if ($urandom_range(1) == 1)
			return bchc_pkg::cfg_word_t'($urandom_range(400));
		return bchc_pkg::cfg_word_t'($urandom_range(65535));
	endfunction

	// A duration on, just past, just short of, or loosely around a threshold.
	function automatic bchc_pkg::ms_t near_ms(input bchc_pkg::cfg_word_t th);
		case ($urandom_range(3))
			0: return bchc_pkg::ms_t'(th);
			1: return bchc_pkg::ms_t'(th) + 1;
			2: return (th == 0) ? '0 : bchc_pkg::ms_t'(th) - 1;
			default: return bchc_pkg::ms_t'($urandom_range(2 * th + 8));
		endcase
	endfunction

	// Hold one level for a span of time with a few polls spread over it. The last
	// step is often cut so that the next edge lands exactly on the span's length.
	task automatic poll_span(input logic level, input bchc_pkg::ms_t dur);
		bchc_pkg::ms_t elapsed;
		bchc_pkg::ms_t dt;
		elapsed = '0;
		do begin
			send_poll(level, clock_ms);
			dt = $urandom_range(1, dur / 3 + 1);
			if (elapsed + dt > dur && $urandom_range(1) == 1)
				dt = dur - elapsed;
			clock_ms += dt;
			elapsed  += dt;
		end while (elapsed < dur);
	endtask

	// A well-formed button gesture: one to three presses with gaps sized against the
	// current thresholds, so clicks, double clicks, holds and long holds all come up.
	task automatic gesture();
		bchc_pkg::cfg_word_t th;
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(2))
				0: th = debounce_cfg;
				1: th = hold_cfg;
				default: th = long_cfg;
			endcase
			poll_span(1'b0, near_ms(th));
			th = ($urandom_range(1) == 1) ? debounce_cfg : gap_cfg;
			poll_span(1'b1, near_ms(th));
		end
		th = ($urandom_range(1) == 1) ? gap_cfg : mem_delay_cfg;
		poll_span(1'b1, near_ms(th) + $urandom_range(3));
	endtask

	// Contact bounce and junk: random levels at short steps, now and then a jump
	// of a random 32-bit amount so that every bit of the time field toggles.
	task automatic noise_burst();
		repeat ($urandom_range(1, 8)) begin
			send_poll(1'($urandom_range(1)), clock_ms);
			if ($urandom_range(9) == 0)
				clock_ms += $urandom();
			else
				clock_ms += $urandom_range(debounce_cfg + 2);
		end
	endtask

	// Random traffic until the given number of further polls has been accepted.
	task automatic run_gestures(input int count);
		int target;
		int pick;
		target = polls_sent + count;
		while (polls_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				gesture();
			end else if (pick < 95) begin
				noise_burst();
			end else if (pick < 97) begin
				// Let the pipeline empty completely before going on.
				wait_drain();
			end else begin
				clock_ms = '1 - $urandom_range(3000);
			end
		end
	endtask

	// Hand-placed polls with the reset settings: the ends of the time range, exact
	// threshold boundaries and each corner of the classifier.
	task automatic test_directed();
		// Stamps reset to all ones, so a press at 10 ms is only 11 ms after the
		// last release and falls inside the debounce window.
		send_poll(1'b1, 32'h0000_0000);
		send_poll(1'b0, 32'h0000_000A);
		// The hold tests still run off the reset press stamp and fire.
		send_poll(1'b0, 32'h0000_0190);
		send_poll(1'b0, 32'h0000_04B0);
		// This release is skipped because a hold has fired.
		send_poll(1'b1, 32'h0000_04BA);
		// Single click: the click shows exactly when the gap has run out.
		send_poll(1'b0, 32'h0000_07D0);
		send_poll(1'b1, 32'h0000_0834);
		send_poll(1'b1, 32'h0000_092D);
		send_poll(1'b1, 32'h0000_092E);
		// Double click: second press one short of the gap, release just past debounce.
		send_poll(1'b0, 32'h0000_0BB8);
		send_poll(1'b1, 32'h0000_0C1C);
		send_poll(1'b0, 32'h0000_0D15);
		send_poll(1'b1, 32'h0000_0D48);
		// A release exactly at the debounce time is not counted; the level still is.
		send_poll(1'b0, 32'h0000_0FA0);
		send_poll(1'b1, 32'h0000_0FD2);
		send_poll(1'b0, 32'h0000_0FDC);
		send_poll(1'b1, 32'h0000_100F);
		send_poll(1'b1, 32'h0000_1130);
		// Hold and long hold crossed in one poll: the long hold is reported.
		send_poll(1'b0, 32'h0000_1388);
		send_poll(1'b0, 32'h0000_1770);
		send_poll(1'b1, 32'h0000_17D4);
		// A click across the wrap of the millisecond timer.
		send_poll(1'b1, 32'hFFFF_FF00);
		send_poll(1'b0, 32'hFFFF_FFFF);
		send_poll(1'b1, 32'h0000_0040);
		send_poll(1'b1, 32'h0000_0200);
		clock_ms = 32'h0000_1000;
	endtask

	// All thresholds at zero: edges count once any time has passed, and holds fire on the press poll itself.
	task automatic test_zero_thresholds();
		load_config('0, '0, '0, '0, '0);
		run_gestures(150);
	endtask

	// All thresholds at their maximum.
	task automatic test_max_thresholds();
		load_config('1, '1, '1, '1, '1);
		run_gestures(150);
	endtask

	// Writes to indexes past the last register must leave the settings alone.
	task automatic test_unknown_index();
		load_config(any_threshold(), any_threshold(), any_threshold(), any_threshold(),
			any_threshold());
		for (int k = int'(bchc_pkg::CFG_MEM_DLY) + 1; k < 2 ** bchc_pkg::IdxWidth; k++)
			write_reg(k[bchc_pkg::IdxWidth-1:0], bchc_pkg::cfg_word_t'($urandom()));
		run_gestures(100);
	endtask

	// Several random settings, with the stall pattern of the two sides swapped.
	task automatic test_random_settings();
		send_idle_pct = 49;
		recv_idle_pct = 23;
		repeat (4) begin
			load_config(any_threshold(), any_threshold(), any_threshold(), any_threshold(),
				any_threshold());
			run_gestures(150);
		end
	endtask

	// Back-to-back beats on both sides, back at the reset settings.
	task automatic test_steady_stream();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_config(bchc_pkg::DebounceRst, bchc_pkg::DcGapRst, bchc_pkg::HoldRst,
			bchc_pkg::LongRst, bchc_pkg::MemDlyRst);
		run_gestures(250);
	endtask

	// The receiver stalls at random; the stall rate changes between tests.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every result beat is checked field by field against the oldest awaited outcome.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: result beat with no poll outstanding: event_code %0d shown_state %0d",
					$time, event_code, shown_state);
				mismatch_count++;
			end else begin
				head_outcome = awaited_outcomes.pop_front();
				if (event_code !== head_outcome.ev) begin
					$display("%0t: event_code expected %0d, got %0d",
						$time, head_outcome.ev, event_code);
					mismatch_count++;
				end
				if (shown_state !== head_outcome.shown) begin
					$display("%0t: shown_state expected %0d, got %0d",
						$time, head_outcome.shown, shown_state);
					mismatch_count++;
				end
			end
		end
	end

	// A hung block shows up as a long run of cycles with no beat and no write.
	always @(posedge clk) begin
		if ((poll_valid && poll_ready) || (result_valid && result_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WatchdogLimit) begin
			$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		clear_classifier();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_zero_thresholds();
		test_max_thresholds();
		test_unknown_index();
		test_random_settings();
		test_steady_stream();
		wait_drain();
		if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/bchc_pkg.sv
rtl/bchc_cfg_regs.sv
rtl/bchc_core.sv
rtl/button_click_hold_classifier_unit.sv
sim/tb.sv
